// ----- src/mcc_pkg.sv -----
// Shared types and constants for the minimum coin change block.
// No dependencies.
package mcc_pkg;

  localparam int VAL_W     = 10;
  localparam int CNT_W     = 11;
  localparam int NUM_COINS = 4;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam logic [CNT_W-1:0] INF_CODE = 11'h7FF;

  localparam logic [2:0]       RST_COIN_COUNT = 3'd4;
  localparam logic [VAL_W-1:0] RST_COIN_A     = 10'd1;
  localparam logic [VAL_W-1:0] RST_COIN_B     = 10'd3;
  localparam logic [VAL_W-1:0] RST_COIN_C     = 10'd4;
  localparam logic [VAL_W-1:0] RST_COIN_D     = 10'd5;

  typedef enum logic [2:0] {
    REG_COIN_COUNT = 3'd0,
    REG_COIN_A     = 3'd1,
    REG_COIN_B     = 3'd2,
    REG_COIN_C     = 3'd3,
    REG_COIN_D     = 3'd4
  } mcc_reg_t;

  typedef struct packed {
    logic [2:0]                           count;
    logic [NUM_COINS-1:0][VAL_W-1:0]      val;
  } mcc_coins_t;

endpackage

// ----- src/min_coin_change.sv -----
// Minimum coin change: one result per target sum; top level with table RAM.
// At most one table read a cycle through the single RAM read port, for each coin in use and each
// row up to the target sum; targets 0 and out of range skip the table fill.
// Throughput: one item at a time; the next item is taken while the result waits.
// Reset: synchronous, active low; coins return to 1, 3, 4, 5; table content undefined.
module min_coin_change
  import mcc_pkg::*;
#(
  parameter int MAX_SUM   = 1023,
  parameter int MAX_COINS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VAL_W-1:0]   in_target_sum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VAL_W-1:0]   out_min_coins,
  output logic               out_reachable
);

  localparam int DEPTH = MAX_SUM + 1;
  localparam int AW    = $clog2(DEPTH);

  mcc_coins_t       coins;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [CNT_W-1:0] mem_rdata;

  mcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coins   (coins)
  );

  mcc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mcc_engine #(
    .MAX_SUM   (MAX_SUM),
    .MAX_COINS (MAX_COINS),
    .AW        (AW)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .coins         (coins),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_target_sum (in_target_sum),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_min_coins (out_min_coins),
    .out_reachable (out_reachable),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule

// ----- src/mcc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mcc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mcc_regs.sv -----
// APB register file for the coin configuration.
// Depends on mcc_pkg.
module mcc_regs
  import mcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output mcc_coins_t         coins
);

  mcc_coins_t coins_r;
  logic       wr_en;
  mcc_reg_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = mcc_reg_t'(paddr[PADDR_W-1:2]);
  assign coins  = coins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coins_r.count  <= RST_COIN_COUNT;
      coins_r.val[0] <= RST_COIN_A;
      coins_r.val[1] <= RST_COIN_B;
      coins_r.val[2] <= RST_COIN_C;
      coins_r.val[3] <= RST_COIN_D;
    end else if (wr_en) begin
      case (idx)
        REG_COIN_COUNT: coins_r.count  <= pwdata[2:0];
        REG_COIN_A:     coins_r.val[0] <= pwdata[VAL_W-1:0];
        REG_COIN_B:     coins_r.val[1] <= pwdata[VAL_W-1:0];
        REG_COIN_C:     coins_r.val[2] <= pwdata[VAL_W-1:0];
        REG_COIN_D:     coins_r.val[3] <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COIN_COUNT: prdata = {29'd0, coins_r.count};
      REG_COIN_A:     prdata = {22'd0, coins_r.val[0]};
      REG_COIN_B:     prdata = {22'd0, coins_r.val[1]};
      REG_COIN_C:     prdata = {22'd0, coins_r.val[2]};
      REG_COIN_D:     prdata = {22'd0, coins_r.val[3]};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- src/mcc_engine.sv -----
// Table-fill sequencer: issues one table read per coin that fits the row, folds the minimum,
// writes each row back with forwarding of the row just written.
// Depends on mcc_pkg; drives the table RAM ports.
module mcc_engine
  import mcc_pkg::*;
#(
  parameter int MAX_SUM   = 1023,
  parameter int MAX_COINS = 4,
  parameter int AW        = $clog2(MAX_SUM + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mcc_coins_t       coins,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_target_sum,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_min_coins,
  output logic             out_reachable,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [CNT_W-1:0] mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [CNT_W-1:0] mem_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FIN} state_t;

  localparam logic [2:0]  MAXC      = 3'(MAX_COINS);
  localparam logic [16:0] MAX_SUM_V = 17'(MAX_SUM);

  state_t           state_r;
  logic [VAL_W-1:0] tgt_r;
  logic [VAL_W-1:0] s_r;
  logic [1:0]       j_r;
  logic             p1_act_r;
  logic             p1_vld_r;
  logic             p1_first_r;
  logic             p1_last_r;
  logic             p1_fwd_r;
  logic [VAL_W-1:0] p1_s_r;
  logic [CNT_W-1:0] fwd_data_r;
  logic [CNT_W-1:0] acc_r;
  logic [VAL_W-1:0] res_cnt_r;
  logic             res_ok_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_min_coins_r;
  logic             out_reachable_r;

  logic             accept;
  logic [2:0]       used;
  logic [1:0]       j_last;
  logic [VAL_W-1:0] coin;
  logic             rd_vld;
  logic [VAL_W-1:0] rd_sum;
  logic [CNT_W-1:0] sub;
  logic [CNT_W-1:0] cand;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] best;
  logic             wr_row;

  assign in_ready      = (state_r == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_min_coins = out_min_coins_r;
  assign out_reachable = out_reachable_r;

  assign used   = (coins.count > MAXC) ? MAXC : coins.count;
  assign j_last = (used == 3'd0) ? 2'd0 : 2'(used - 3'd1);
  assign coin   = coins.val[j_r];
  assign rd_vld = (state_r == S_RUN) && ({1'b0, j_r} < used) && (coin != '0) && (coin <= s_r);
  assign rd_sum = s_r - coin;

  assign sub    = p1_fwd_r ? fwd_data_r : mem_rdata;
  assign cand   = (p1_vld_r && (sub != INF_CODE)) ? sub + 11'd1 : INF_CODE;
  assign base   = p1_first_r ? INF_CODE : acc_r;
  assign best   = (cand < base) ? cand : base;
  assign wr_row = p1_act_r && p1_last_r;

  assign mem_we    = accept || wr_row;
  assign mem_waddr = accept ? '0 : AW'(p1_s_r);
  assign mem_wdata = accept ? '0 : best;
  assign mem_raddr = AW'(rd_sum);

  // read pipeline and running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_act_r <= 1'b0;
      p1_fwd_r <= 1'b0;
    end else begin
      p1_act_r   <= (state_r == S_RUN);
      p1_fwd_r   <= rd_vld && mem_we && (mem_waddr == mem_raddr);
      p1_vld_r   <= rd_vld;
      p1_first_r <= (j_r == 2'd0);
      p1_last_r  <= (j_r == j_last);
      p1_s_r     <= s_r;
      fwd_data_r <= mem_wdata;
      if (p1_act_r) begin
        acc_r <= best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            tgt_r <= in_target_sum;
            s_r   <= 10'd1;
            j_r   <= 2'd0;
            if ({7'd0, in_target_sum} > MAX_SUM_V) begin
              res_cnt_r <= '0;
              res_ok_r  <= 1'b0;
              state_r   <= S_FIN;
            end else if (in_target_sum == '0) begin
              res_cnt_r <= '0;
              res_ok_r  <= 1'b1;
              state_r   <= S_FIN;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (j_r == j_last) begin
            j_r <= 2'd0;
            if (s_r == tgt_r) begin
              state_r <= S_DRAIN;
            end else begin
              s_r <= s_r + 10'd1;
            end
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_DRAIN: begin
          if (wr_row) begin
            res_ok_r  <= (best != INF_CODE);
            res_cnt_r <= (best != INF_CODE) ? best[VAL_W-1:0] : '0;
            state_r   <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_min_coins_r <= res_cnt_r;
            out_reachable_r <= res_ok_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    p1_fwd_r |-> $past(mem_we))
    else $error("forward taken without a write in the previous cycle");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !p1_act_r)
    else $error("read pipeline busy while idle");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p1_act_r |-> (p1_s_r <= tgt_r))
    else $error("row written beyond target");

  a_read_below: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld |-> (rd_sum < s_r))
    else $error("table read at or above current row");

endmodule

// ----- verif/min_coin_change_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for min_coin_change: targets go in over valid/ready,
// coin settings are written over the APB port, and every result is checked.
// Depends on mcc_pkg and the min_coin_change top level.
module min_coin_change_tb
  import mcc_pkg::*;
();

  localparam int         MAX_SUM      = 1023;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int         DRAIN_LIMIT  = 40000;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         ITEM_GOAL    = 140;

  typedef struct packed {
    logic [VAL_W-1:0] target;
    logic [VAL_W-1:0] min_coins;
    logic             reachable;
  } change_t;

  class coin_scoreboard;
    mcc_coins_t coins;
    int         sum_counts [0:MAX_SUM];
    change_t    owed [$];
    int         errors;
    int         checked;

    function new();
      coins.count  = RST_COIN_COUNT;
      coins.val[0] = RST_COIN_A;
      coins.val[1] = RST_COIN_B;
      coins.val[2] = RST_COIN_C;
      coins.val[3] = RST_COIN_D;
      errors       = 0;
      checked      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [PDATA_W-1:0] data);
      case (idx)
        REG_COIN_COUNT: coins.count  = data[2:0];
        REG_COIN_A:     coins.val[0] = data[VAL_W-1:0];
        REG_COIN_B:     coins.val[1] = data[VAL_W-1:0];
        REG_COIN_C:     coins.val[2] = data[VAL_W-1:0];
        REG_COIN_D:     coins.val[3] = data[VAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_COIN_COUNT: return PDATA_W'(coins.count);
        REG_COIN_A:     return PDATA_W'(coins.val[0]);
        REG_COIN_B:     return PDATA_W'(coins.val[1]);
        REG_COIN_C:     return PDATA_W'(coins.val[2]);
        REG_COIN_D:     return PDATA_W'(coins.val[3]);
        default:        return '0;
      endcase
    endfunction

    // Fill the count table bottom-up and queue the count for the target.
    function void note_target(logic [VAL_W-1:0] target);
      int      used;
      int      s;
      int      j;
      int      c;
      int      best;
      int      sub;
      change_t fewest;
      used = (coins.count > NUM_COINS) ? NUM_COINS : int'(coins.count);
      sum_counts[0] = 0;
      for (s = 1; s <= int'(target); s++) begin
        best = INF_CODE;
        for (j = 0; j < used; j++) begin
          c = coins.val[j];
          if (c != 0 && c <= s) begin
            sub = sum_counts[s - c];
            if (sub != INF_CODE && sub + 1 < best) best = sub + 1;
          end
        end
        sum_counts[s] = best;
      end
      fewest.target = target;
      if (sum_counts[target] == INF_CODE) begin
        fewest.min_coins = '0;
        fewest.reachable = 1'b0;
      end else begin
        fewest.min_coins = VAL_W'(sum_counts[target]);
        fewest.reachable = 1'b1;
      end
      owed.push_back(fewest);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [VAL_W-1:0] min_coins, logic reachable);
      change_t want;
      checked++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("word %0d/%0b with no target pending", min_coins, reachable));
      end else begin
        want = owed.pop_front();
        if (min_coins !== want.min_coins)
          report_mismatch($sformatf("target %0d: min_coins %0d, want %0d",
                                    want.target, min_coins, want.min_coins));
        if (reachable !== want.reachable)
          report_mismatch($sformatf("target %0d: reachable %0b, want %0b",
                                    want.target, reachable, want.reachable));
      end
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [VAL_W-1:0]   in_target_sum;
  logic               out_valid;
  logic               out_ready;
  logic [VAL_W-1:0]   out_min_coins;
  logic               out_reachable;

  coin_scoreboard sb;
  bit             quiet;
  bit             hold_req;
  int             items_sent;
  int             settings;

  min_coin_change #(
    .MAX_SUM  (1023),
    .MAX_COINS(4)
  ) u_top (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #30_000_000;
    $display("min_coin_change_tb NOT OK");
    $finish;
  end

  function automatic int idle_gap();
    if (quiet) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(2);
  endfunction

  // Result side: random back-pressure plus a long hold-off on request.
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(3) == 0) begin
        stall_left = idle_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_min_coins, out_reachable);
  end

  task apb_access(input bit wr, input logic [2:0] idx, input logic [PDATA_W-1:0] data,
                  output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    if (wr) pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] unused;
    apb_access(1'b1, idx, data, unused);
    sb.set_reg(idx, data);
  endtask

  task check_reg(input logic [2:0] idx);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== sb.reg_value(idx))
      sb.report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                   idx, rd, sb.reg_value(idx)));
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_target(input logic [VAL_W-1:0] target, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_target_sum <= target;
    do @(posedge clk); while (!in_ready);
    sb.note_target(target);
    items_sent++;
    @(negedge clk);
  endtask

  task drain();
    int k;
    for (k = 0; k < DRAIN_LIMIT && sb.pending() != 0; k++) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task load_coins(input logic [2:0] count, input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                  input logic [VAL_W-1:0] c, input logic [VAL_W-1:0] d, input bit junk);
    logic [PDATA_W-1:0] hi;
    int                 i;
    in_valid <= 1'b0;
    drain();
    hi = junk ? $urandom() : '0;
    write_reg(REG_COIN_COUNT, {hi[PDATA_W-1:3], count});
    write_reg(REG_COIN_A, {hi[PDATA_W-1:VAL_W], a});
    write_reg(REG_COIN_B, {hi[PDATA_W-1:VAL_W], b});
    write_reg(REG_COIN_C, {hi[PDATA_W-1:VAL_W], c});
    write_reg(REG_COIN_D, {hi[PDATA_W-1:VAL_W], d});
    for (i = 0; i < NUM_COINS + 1; i++) check_reg(3'(i));
    settings++;
  endtask

  function automatic logic [VAL_W-1:0] rand_coin();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return VAL_W'($urandom_range(1023));
    return VAL_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [VAL_W-1:0] rand_target();
    int r;
    r = $urandom_range(19);
    if (r == 0) return VAL_W'($urandom_range(1023));
    if (r < 5) return VAL_W'($urandom_range(200));
    return VAL_W'($urandom_range(40));
  endfunction

  initial begin
    int         i;
    int         phase;
    int         burst;
    int         r;
    logic [2:0] count;
    sb            = new();
    quiet         = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    settings      = 1;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_target_sum = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < NUM_COINS + 1; i++) check_reg(3'(i));

    send_target(10'd0, idle_gap());
    send_target(10'd1, idle_gap());
    send_target(10'd2, idle_gap());
    send_target(10'd7, idle_gap());
    send_target(10'd11, idle_gap());
    send_target(10'd1023, idle_gap());
    send_target(10'd341, idle_gap());
    send_target(10'd682, idle_gap());

    // no coin in use
    load_coins(3'd0, 10'd1, 10'd3, 10'd4, 10'd5, 1'b0);
    send_target(10'd0, idle_gap());
    send_target(10'd5, idle_gap());

    // count above the coin limit, one coin of value zero
    load_coins(3'd7, 10'd2, 10'd9, 10'd0, 10'd1023, 1'b0);
    send_target(10'd1, idle_gap());
    send_target(10'd13, idle_gap());
    send_target(10'd1023, idle_gap());

    load_coins(3'd2, 10'd0, 10'd7, 10'd1, 10'd1, 1'b1);
    send_target(10'd14, idle_gap());
    send_target(10'd3, idle_gap());

    load_coins(3'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_target(10'd1023, idle_gap());
    send_target(10'd1022, idle_gap());

    load_coins(3'd1, 10'd1, 10'd1, 10'd1, 10'd1, 1'b0);
    send_target(10'd1023, idle_gap());

    // writes past the register list leave the coins alone
    in_valid <= 1'b0;
    drain();
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '1);
    for (i = 0; i < NUM_COINS + 1; i++) check_reg(3'(i));
    send_target(10'd1000, idle_gap());

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      r     = $urandom_range(15);
      count = (r < 12) ? 3'(1 + r % 4) : 3'($urandom_range(7));
      quiet = 1'b0;
      load_coins(count, rand_coin(), rand_coin(), rand_coin(), rand_coin(),
                 $urandom_range(3) == 0);
      quiet = (phase == 2);
      if (phase == 3) begin
        // hold the result side and offer ten targets back to back so that the input stalls
        hold_req = 1'b1;
        for (i = 0; i < 10; i++) send_target(10'($urandom_range(30)), 0);
      end else begin
        burst = $urandom_range(14, 8);
        for (i = 0; i < burst; i++) send_target(rand_target(), idle_gap());
      end
      phase++;
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Ran %0d targets, checked %0d results over %0d coin settings,", items_sent,
             sb.checked, settings);
    $display("including no coins, saturated count, zero coins, 1023 coins and spare writes.");
    if (sb.errors == 0) begin
      $display("min_coin_change_tb OK");
    end else begin
      $display("min_coin_change_tb NOT OK");
    end
    $finish;
  end

endmodule
